// ===== design/mqp_pkg.sv =====
package mqp_pkg;

    localparam int unsigned POS_W   = 8;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned DIGIT_W = 7;
    localparam int unsigned NUM_W   = 27;
    localparam int unsigned SYM_W   = 48;
    localparam int unsigned PRICE_W = 20;

    localparam logic [POS_W-1:0] POS_SEQ_LO    = 8'd6;
    localparam logic [POS_W-1:0] POS_SEQ_HI    = 8'd9;
    localparam logic [POS_W-1:0] POS_SYM_LO    = 8'd10;
    localparam logic [POS_W-1:0] POS_SYM_HI    = 8'd15;
    localparam logic [POS_W-1:0] POS_TIME_LO   = 8'd16;
    localparam logic [POS_W-1:0] POS_TIME_HI   = 8'd21;
    localparam logic [POS_W-1:0] POS_FLAGS     = 8'd22;
    localparam logic [POS_W-1:0] POS_STATUS    = 8'd24;
    localparam logic [POS_W-1:0] POS_VOL_LO    = 8'd25;
    localparam logic [POS_W-1:0] POS_VOL_HI    = 8'd28;
    localparam logic [POS_W-1:0] POS_REC_START = 8'd29;
    localparam logic [POS_W-1:0] POS_SUMMARY   = 8'd31;
    localparam logic [POS_W-1:0] POS_MAX       = 8'd255;
    localparam logic [POS_W-1:0] MIN_MSG_LEN   = 8'd32;

    localparam logic [PHASE_W-1:0] PHASE_QTY_FIRST = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_LAST      = 3'd6;

    localparam logic [7:0] ASCII_SPACE  = 8'h20;
    localparam int unsigned FLAG_TRADE   = 7;
    localparam int unsigned FLAG_NO_BOOK = 0;
    localparam int unsigned STATUS_SIM   = 7;

    typedef enum logic [2:0] {
        KIND_SUMMARY = 3'd0,
        KIND_TRADE   = 3'd1,
        KIND_BID     = 3'd2,
        KIND_ASK     = 3'd3,
        KIND_END     = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              record_kind;
        logic [NUM_W-1:0]   sequence_number;
        logic [SYM_W-1:0]   symbol_code;
        logic [SYM_W-1:0]   match_time;
        logic [NUM_W-1:0]   total_volume;
        logic [PRICE_W-1:0] price_cents;
        logic [NUM_W-1:0]   quantity;
        logic [2:0]         level_index;
        logic [1:0]         content_mask;
        logic               digit_error;
        logic               truncated;
        logic               last_of_run;
    } rec_t;

    typedef struct packed {
        logic valid;
        logic two;
        rec_t first;
        rec_t second;
    } pair_t;

    typedef struct packed {
        logic               bad;
        logic [DIGIT_W-1:0] value;
    } bcd_t;

    function automatic bcd_t bcd_byte(input logic [7:0] b);
        logic [3:0] hi;
        logic [3:0] lo;
        bcd_t       r;
        hi = b[7:4];
        lo = b[3:0];
        r.bad = (hi > 4'd9) || (lo > 4'd9);
        if (hi > 4'd9)
        begin
            hi = 4'd9;
        end
        if (lo > 4'd9)
        begin
            lo = 4'd9;
        end
        r.value = {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
        return r;
    endfunction

    function automatic logic [NUM_W-1:0] acc100_num(input logic [NUM_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] d);
        return {a[NUM_W-7:0], 6'b0} + {a[NUM_W-6:0], 5'b0} + {a[NUM_W-3:0], 2'b0}
             + {{(NUM_W-DIGIT_W){1'b0}}, d};
    endfunction

    function automatic logic [PRICE_W-1:0] acc100_price(input logic [PRICE_W-1:0] a,
                                                       input logic [DIGIT_W-1:0] d);
        return {a[PRICE_W-7:0], 6'b0} + {a[PRICE_W-6:0], 5'b0} + {a[PRICE_W-3:0], 2'b0}
             + {{(PRICE_W-DIGIT_W){1'b0}}, d};
    endfunction

    function automatic logic [CNT_W-1:0] record_total(input logic [7:0] flags,
                                                     input logic sim);
        logic [CNT_W-1:0] n;
        n = {3'b000, flags[FLAG_TRADE]};
        if (!flags[FLAG_NO_BOOK])
        begin
            n = n + {1'b0, flags[6:4]} + {1'b0, flags[3:1]};
        end
        if (sim)
        begin
            n = '0;
        end
        return n;
    endfunction

endpackage

// ===== design/mqp_feed_if.sv =====
interface mqp_feed_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ===== design/mqp_rec_if.sv =====
interface mqp_rec_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [26:0] sequence_number;
    logic [47:0] symbol_code;
    logic [47:0] match_time;
    logic [26:0] total_volume;
    logic [19:0] price_cents;
    logic [26:0] quantity;
    logic [2:0]  level_index;
    logic [1:0]  content_mask;
    logic        digit_error;
    logic        truncated;
    logic        last_of_run;

    modport source (
        output valid, input ready,
        output record_kind, output sequence_number, output symbol_code,
        output match_time, output total_volume, output price_cents,
        output quantity, output level_index, output content_mask,
        output digit_error, output truncated, output last_of_run
    );
    modport sink (
        input valid, output ready,
        input record_kind, input sequence_number, input symbol_code,
        input match_time, input total_volume, input price_cents,
        input quantity, input level_index, input content_mask,
        input digit_error, input truncated, input last_of_run
    );
endinterface

// ===== design/mqp_parse.sv =====
module mqp_parse (
    input  logic            clk,
    input  logic            rst_n,
    mqp_feed_if.sink        feed,
    input  logic            buf_ready,
    output mqp_pkg::pair_t  result_pair
);

    logic                             in_valid_reg;
    logic [7:0]                       byte_reg;
    logic                             eom_reg;
    logic                             fire;

    logic [mqp_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [mqp_pkg::NUM_W-1:0]        seq_reg, seq_next, seq_upd;
    logic [mqp_pkg::SYM_W-1:0]        sym_reg, sym_next, sym_upd;
    logic                             space_reg, space_next, space_upd;
    logic [mqp_pkg::SYM_W-1:0]        time_reg, time_next, time_upd;
    logic [7:0]                       flags_reg, flags_next, flags_upd;
    logic                             sim_reg, sim_next, sim_upd;
    logic [mqp_pkg::NUM_W-1:0]        vol_reg, vol_next, vol_upd;
    logic [mqp_pkg::PRICE_W-1:0]      price_reg, price_next, price_upd;
    logic [mqp_pkg::NUM_W-1:0]        qty_reg, qty_next, qty_upd;
    logic [mqp_pkg::CNT_W-1:0]        lvl_cnt_reg, lvl_cnt_next, lvl_cnt_upd;
    logic [1:0]                       err_reg, err_next, err_upd;
    logic [1:0]                       mask_reg, mask_next, mask_upd;
    logic [mqp_pkg::PHASE_W-1:0]      phase_reg, phase_next, phase_upd;

    mqp_pkg::bcd_t                    bcd;
    logic [mqp_pkg::CNT_W-1:0]        total;
    logic                             is_summary;
    logic                             rec_active;
    logic                             rec_done;
    logic                             is_trade;
    logic [mqp_pkg::CNT_W-1:0]        rec_j;
    logic [2:0]                       nbid;
    logic [mqp_pkg::POS_W-1:0]        need;
    logic [mqp_pkg::POS_W-1:0]        times7;
    logic                             trunc;
    mqp_pkg::rec_t                    base_rec;
    mqp_pkg::rec_t                    sum_rec;
    mqp_pkg::rec_t                    lvl_rec;
    mqp_pkg::rec_t                    end_rec;

    assign fire       = in_valid_reg && buf_ready;
    assign feed.ready = !in_valid_reg || buf_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (feed.ready)
        begin
            in_valid_reg <= feed.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed.ready && feed.valid)
        begin
            byte_reg <= feed.data_byte;
            eom_reg  <= feed.end_of_message;
        end
    end

    always_comb
    begin
        bcd        = mqp_pkg::bcd_byte(byte_reg);
        seq_upd    = seq_reg;
        sym_upd    = sym_reg;
        space_upd  = space_reg;
        time_upd   = time_reg;
        flags_upd  = flags_reg;
        sim_upd    = sim_reg;
        vol_upd    = vol_reg;
        price_upd  = price_reg;
        qty_upd    = qty_reg;
        lvl_cnt_upd = lvl_cnt_reg;
        err_upd    = err_reg;
        mask_upd   = mask_reg;
        phase_upd  = phase_reg;

        if (pos_reg >= mqp_pkg::POS_SEQ_LO && pos_reg <= mqp_pkg::POS_SEQ_HI)
        begin
            seq_upd = mqp_pkg::acc100_num(seq_reg, bcd.value);
            if (bcd.bad)
            begin
                err_upd[0] = 1'b1;
            end
        end
        else if (pos_reg >= mqp_pkg::POS_SYM_LO && pos_reg <= mqp_pkg::POS_SYM_HI)
        begin
            space_upd = space_reg || (byte_reg == mqp_pkg::ASCII_SPACE);
            sym_upd   = {sym_reg[mqp_pkg::SYM_W-9:0], space_upd ? 8'h00 : byte_reg};
        end
        else if (pos_reg >= mqp_pkg::POS_TIME_LO && pos_reg <= mqp_pkg::POS_TIME_HI)
        begin
            time_upd = {time_reg[mqp_pkg::SYM_W-9:0], byte_reg};
        end
        else if (pos_reg == mqp_pkg::POS_FLAGS)
        begin
            flags_upd = byte_reg;
        end
        else if (pos_reg == mqp_pkg::POS_STATUS)
        begin
            sim_upd  = byte_reg[mqp_pkg::STATUS_SIM];
            mask_upd = sim_upd ? 2'b00
                     : {!flags_reg[mqp_pkg::FLAG_NO_BOOK], flags_reg[mqp_pkg::FLAG_TRADE]};
        end
        else if (pos_reg >= mqp_pkg::POS_VOL_LO && pos_reg <= mqp_pkg::POS_VOL_HI)
        begin
            vol_upd = mqp_pkg::acc100_num(vol_reg, bcd.value);
            if (bcd.bad)
            begin
                err_upd[0] = 1'b1;
            end
        end

        total      = mqp_pkg::record_total(flags_reg, sim_reg);
        is_summary = (pos_reg == mqp_pkg::POS_SUMMARY);
        rec_active = (pos_reg >= mqp_pkg::POS_REC_START) && (lvl_cnt_reg < total);
        rec_done   = rec_active && (phase_reg == mqp_pkg::PHASE_LAST);

        if (rec_active)
        begin
            if (phase_reg < mqp_pkg::PHASE_QTY_FIRST)
            begin
                price_upd = mqp_pkg::acc100_price(price_reg, bcd.value);
            end
            else
            begin
                qty_upd = mqp_pkg::acc100_num(qty_reg, bcd.value);
            end
            if (bcd.bad)
            begin
                err_upd[1] = 1'b1;
            end
        end

        // The record phase follows the byte position from the first record byte on.
        if (pos_reg >= mqp_pkg::POS_REC_START && pos_reg != mqp_pkg::POS_MAX)
        begin
            phase_upd = (phase_reg == mqp_pkg::PHASE_LAST) ? '0 : phase_reg + 3'd1;
        end

        is_trade = flags_reg[mqp_pkg::FLAG_TRADE];
        nbid     = flags_reg[6:4];
        rec_j    = lvl_cnt_reg - {3'b000, is_trade};

        base_rec                 = '0;
        base_rec.sequence_number = seq_upd;
        base_rec.symbol_code     = sym_upd;
        base_rec.match_time      = time_upd;
        base_rec.total_volume    = vol_upd;

        sum_rec             = base_rec;
        sum_rec.record_kind = mqp_pkg::KIND_SUMMARY;
        sum_rec.digit_error = err_upd[0];

        lvl_rec             = base_rec;
        lvl_rec.price_cents = price_upd;
        lvl_rec.quantity    = qty_upd;
        lvl_rec.digit_error = err_upd[1];
        if (is_trade && lvl_cnt_reg == '0)
        begin
            lvl_rec.record_kind = mqp_pkg::KIND_TRADE;
        end
        else if (rec_j < {1'b0, nbid})
        begin
            lvl_rec.record_kind = mqp_pkg::KIND_BID;
            lvl_rec.level_index = rec_j[2:0];
        end
        else
        begin
            lvl_rec.record_kind = mqp_pkg::KIND_ASK;
            lvl_rec.level_index = rec_j[2:0] - nbid;
        end

        if (rec_done)
        begin
            price_upd   = '0;
            qty_upd     = '0;
            err_upd[1]  = 1'b0;
            lvl_cnt_upd = lvl_cnt_reg + 4'd1;
        end

        times7 = {1'b0, total, 3'b000} - {4'b0000, total};
        need   = mqp_pkg::POS_REC_START + times7;
        if (need < mqp_pkg::MIN_MSG_LEN)
        begin
            need = mqp_pkg::MIN_MSG_LEN;
        end
        if (pos_reg <= mqp_pkg::POS_STATUS)
        begin
            trunc = 1'b1;
        end
        else
        begin
            trunc = ({1'b0, pos_reg} + 9'd1) < {1'b0, need};
        end

        end_rec              = base_rec;
        end_rec.record_kind  = mqp_pkg::KIND_END;
        end_rec.content_mask = mask_upd;
        end_rec.digit_error  = err_upd[0];
        end_rec.truncated    = trunc;
        end_rec.last_of_run  = 1'b1;

        result_pair.valid = fire && (is_summary || rec_done || eom_reg);
        result_pair.two   = eom_reg && (is_summary || rec_done);
        priority if (is_summary)
        begin
            result_pair.first = sum_rec;
        end
        else if (rec_done)
        begin
            result_pair.first = lvl_rec;
        end
        else
        begin
            result_pair.first = end_rec;
        end
        result_pair.first.last_of_run = !result_pair.two;
        result_pair.second            = end_rec;

        if (eom_reg)
        begin
            pos_next     = '0;
            seq_next     = '0;
            sym_next     = '0;
            space_next   = 1'b0;
            time_next    = '0;
            flags_next   = '0;
            sim_next     = 1'b0;
            vol_next     = '0;
            price_next   = '0;
            qty_next     = '0;
            lvl_cnt_next = '0;
            err_next     = '0;
            mask_next    = '0;
            phase_next   = '0;
        end
        else
        begin
            pos_next     = (pos_reg == mqp_pkg::POS_MAX) ? pos_reg : pos_reg + 8'd1;
            seq_next     = seq_upd;
            sym_next     = sym_upd;
            space_next   = space_upd;
            time_next    = time_upd;
            flags_next   = flags_upd;
            sim_next     = sim_upd;
            vol_next     = vol_upd;
            price_next   = price_upd;
            qty_next     = qty_upd;
            lvl_cnt_next = lvl_cnt_upd;
            err_next     = err_upd;
            mask_next    = mask_upd;
            phase_next   = phase_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            seq_reg     <= '0;
            sym_reg     <= '0;
            space_reg   <= 1'b0;
            time_reg    <= '0;
            flags_reg   <= '0;
            sim_reg     <= 1'b0;
            vol_reg     <= '0;
            price_reg   <= '0;
            qty_reg     <= '0;
            lvl_cnt_reg <= '0;
            err_reg     <= '0;
            mask_reg    <= '0;
            phase_reg   <= '0;
        end
        else if (fire)
        begin
            pos_reg     <= pos_next;
            seq_reg     <= seq_next;
            sym_reg     <= sym_next;
            space_reg   <= space_next;
            time_reg    <= time_next;
            flags_reg   <= flags_next;
            sim_reg     <= sim_next;
            vol_reg     <= vol_next;
            price_reg   <= price_next;
            qty_reg     <= qty_next;
            lvl_cnt_reg <= lvl_cnt_next;
            err_reg     <= err_next;
            mask_reg    <= mask_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

// ===== design/mqp_out_buf.sv =====
module mqp_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  mqp_pkg::pair_t  result_pair,
    output logic            buf_ready,
    mqp_rec_if.source       records
);

    logic          out_valid_reg;
    logic          pend_valid_reg;
    mqp_pkg::rec_t out_reg;
    mqp_pkg::rec_t pend_reg;
    logic          taken;

    assign taken     = out_valid_reg && records.ready;
    assign buf_ready = !out_valid_reg || (records.ready && !pend_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (result_pair.valid)
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= result_pair.two;
        end
        else if (taken)
        begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_pair.valid)
        begin
            out_reg  <= result_pair.first;
            pend_reg <= result_pair.second;
        end
        else if (taken && pend_valid_reg)
        begin
            out_reg <= pend_reg;
        end
    end

    assign records.valid           = out_valid_reg;
    assign records.record_kind     = out_reg.record_kind;
    assign records.sequence_number = out_reg.sequence_number;
    assign records.symbol_code     = out_reg.symbol_code;
    assign records.match_time      = out_reg.match_time;
    assign records.total_volume    = out_reg.total_volume;
    assign records.price_cents     = out_reg.price_cents;
    assign records.quantity        = out_reg.quantity;
    assign records.level_index     = out_reg.level_index;
    assign records.content_mask    = out_reg.content_mask;
    assign records.digit_error     = out_reg.digit_error;
    assign records.truncated       = out_reg.truncated;
    assign records.last_of_run     = out_reg.last_of_run;

endmodule

// ===== design/market_quote_message_parser.sv =====
// A byte waits in the input register until the output stage has room; its first record
// then goes to the output register and a second one to the pending register, which moves
// up once the first is taken. Throughput: one byte per cycle while records are taken; a
// byte that ends a message after a summary or a price record holds the input until both
// drain. Reset: rst_n clears the parser state and both buffer valids; no clearing pass.
module market_quote_message_parser (
    input  logic       clk,
    input  logic       rst_n,
    mqp_feed_if.sink   feed,
    mqp_rec_if.source  records
);

    mqp_pkg::pair_t result_pair;
    logic           buf_ready;

    mqp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .feed        (feed),
        .buf_ready   (buf_ready),
        .result_pair (result_pair)
    );

    mqp_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .result_pair (result_pair),
        .buf_ready   (buf_ready),
        .records     (records)
    );

    // The parser only writes a record pair when the output stage has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_pair.valid |-> buf_ready)
        else $error("record pair written into a full output stage");

    // A byte with two records always ends its message with the end record last.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_pair.valid && result_pair.two |->
            result_pair.second.record_kind == mqp_pkg::KIND_END
            && result_pair.second.last_of_run && !result_pair.first.last_of_run)
        else $error("second record of a pair is not a closing end record");

    // The end record is always the last record of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        records.valid && records.record_kind == mqp_pkg::KIND_END |-> records.last_of_run)
        else $error("end record not marked last of run");

endmodule

// ===== bench/tb_market_quote_message_parser.sv =====
`timescale 1ns / 100ps

module tb_market_quote_message_parser;

    import mqp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
    } quote_byte_t;

    logic clk;
    logic rst_n;

    mqp_feed_if feed ();
    mqp_rec_if  records ();

    market_quote_message_parser i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .feed    (feed),
        .records (records)
    );

    quote_byte_t pending_bytes[$];
    rec_t        expected_records[$];

    int unsigned bytes_taken = 0;
    int unsigned mismatch_count = 0;
    int          send_gap;
    int          take_stall;
    logic        send_quiet = 1'b0;
    logic        take_quiet = 1'b0;
    logic        hold_off;
    quote_byte_t next_byte;
    rec_t        got_record;

    // Parser state of the predictor.
    logic [POS_W-1:0]   parse_pos;
    logic [NUM_W-1:0]   seq_acc;
    logic [SYM_W-1:0]   sym_acc;
    logic               sym_space;
    logic [SYM_W-1:0]   time_acc;
    logic [7:0]         flags_reg;
    logic               sim_reg;
    logic [NUM_W-1:0]   vol_acc;
    logic [PRICE_W-1:0] price_acc;
    logic [NUM_W-1:0]   qty_acc;
    logic [CNT_W-1:0]   records_done;
    logic [1:0]         err_reg;
    logic [1:0]         mask_reg;

    function automatic logic [6:0] bcd_value(input logic [7:0] b, output logic bad);
        int hi;
        int lo;
        hi = b[7:4];
        lo = b[3:0];
        bad = (hi > 9) || (lo > 9);
        if (hi > 9)
        begin
            hi = 9;
        end
        if (lo > 9)
        begin
            lo = 9;
        end
        return 7'(hi * 10 + lo);
    endfunction

    function automatic int count_records(input logic [7:0] flags, input logic sim);
        int n;
        n = 0;
        if (!sim)
        begin
            n = flags[FLAG_TRADE];
            if (!flags[FLAG_NO_BOOK])
            begin
                n = n + flags[6:4] + flags[3:1];
            end
        end
        return n;
    endfunction

    function automatic rec_t make_record(input kind_t kind, input logic [PRICE_W-1:0] price,
                                         input logic [NUM_W-1:0] qty, input logic [2:0] lvl,
                                         input logic [1:0] mask, input logic derr,
                                         input logic trunc);
        rec_t r;
        r.record_kind     = kind;
        r.sequence_number = seq_acc;
        r.symbol_code     = sym_acc;
        r.match_time      = time_acc;
        r.total_volume    = vol_acc;
        r.price_cents     = price;
        r.quantity        = qty;
        r.level_index     = lvl;
        r.content_mask    = mask;
        r.digit_error     = derr;
        r.truncated       = trunc;
        r.last_of_run     = 1'b0;
        return r;
    endfunction

    task automatic clear_parser();
        parse_pos    = '0;
        seq_acc      = '0;
        sym_acc      = '0;
        sym_space    = 1'b0;
        time_acc     = '0;
        flags_reg    = '0;
        sim_reg      = 1'b0;
        vol_acc      = '0;
        price_acc    = '0;
        qty_acc      = '0;
        records_done = '0;
        err_reg      = '0;
        mask_reg     = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic eom);
        rec_t        outs[2];
        int          n;
        int          pos;
        int          phase;
        int          slot;
        int          nbid;
        int          need;
        logic        bad;
        logic        trunc;
        logic [6:0]  d;
        logic [2:0]  lvl;
        kind_t       kind;
        n = 0;
        pos = parse_pos;
        d = bcd_value(b, bad);
        if (pos >= POS_SEQ_LO && pos <= POS_SEQ_HI)
        begin
            seq_acc = NUM_W'(64'(seq_acc) * 100 + d);
            if (bad)
            begin
                err_reg[0] = 1'b1;
            end
        end
        else if (pos >= POS_SYM_LO && pos <= POS_SYM_HI)
        begin
            if (!sym_space && b == ASCII_SPACE)
            begin
                sym_space = 1'b1;
            end
            sym_acc = {sym_acc[SYM_W-9:0], sym_space ? 8'h00 : b};
        end
        else if (pos >= POS_TIME_LO && pos <= POS_TIME_HI)
        begin
            time_acc = {time_acc[SYM_W-9:0], b};
        end
        else if (pos == POS_FLAGS)
        begin
            flags_reg = b;
        end
        else if (pos == POS_STATUS)
        begin
            sim_reg = b[STATUS_SIM];
            mask_reg = sim_reg ? 2'b00 : {~flags_reg[FLAG_NO_BOOK], flags_reg[FLAG_TRADE]};
        end
        else if (pos >= POS_VOL_LO && pos <= POS_VOL_HI)
        begin
            vol_acc = NUM_W'(64'(vol_acc) * 100 + d);
            if (bad)
            begin
                err_reg[0] = 1'b1;
            end
        end

        if (pos == POS_SUMMARY)
        begin
            outs[n] = make_record(KIND_SUMMARY, '0, '0, '0, '0, err_reg[0], 1'b0);
            n++;
        end

        if (pos >= POS_REC_START && records_done < count_records(flags_reg, sim_reg))
        begin
            phase = (pos - POS_REC_START) % 7;
            if (phase < PHASE_QTY_FIRST)
            begin
                price_acc = PRICE_W'(64'(price_acc) * 100 + d);
            end
            else
            begin
                qty_acc = NUM_W'(64'(qty_acc) * 100 + d);
            end
            if (bad)
            begin
                err_reg[1] = 1'b1;
            end
            if (phase == PHASE_LAST)
            begin
                nbid = flags_reg[6:4];
                lvl = '0;
                if (flags_reg[FLAG_TRADE] && records_done == 0)
                begin
                    kind = KIND_TRADE;
                end
                else
                begin
                    slot = records_done - flags_reg[FLAG_TRADE];
                    if (slot < nbid)
                    begin
                        kind = KIND_BID;
                        lvl = 3'(slot);
                    end
                    else
                    begin
                        kind = KIND_ASK;
                        lvl = 3'(slot - nbid);
                    end
                end
                outs[n] = make_record(kind, price_acc, qty_acc, lvl, '0, err_reg[1], 1'b0);
                n++;
                price_acc = '0;
                qty_acc = '0;
                err_reg[1] = 1'b0;
                records_done = records_done + 1'b1;
            end
        end

        if (pos < POS_MAX)
        begin
            parse_pos = parse_pos + 1'b1;
        end

        if (eom)
        begin
            if (pos <= POS_STATUS)
            begin
                trunc = 1'b1;
            end
            else
            begin
                need = POS_REC_START + 7 * count_records(flags_reg, sim_reg);
                if (need < MIN_MSG_LEN)
                begin
                    need = MIN_MSG_LEN;
                end
                trunc = (pos + 1 < need);
            end
            outs[n] = make_record(KIND_END, '0, '0, '0, mask_reg, err_reg[0], trunc);
            n++;
            clear_parser();
        end

        if (n > 0)
        begin
            outs[n-1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            expected_records.push_back(outs[i]);
        end
    endtask

    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] digit_byte();
        if ($urandom_range(0, 19) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        return 8'({4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))});
    endfunction

    task automatic queue_message(input logic [7:0] body[$]);
        quote_byte_t item;
        for (int i = 0; i < body.size(); i++)
        begin
            item.data = body[i];
            item.eom = (i == body.size() - 1);
            pending_bytes.push_back(item);
        end
    endtask

    task automatic queue_quote(input int shape);
        logic [7:0] body[$];
        logic [7:0] flags;
        logic [7:0] status;
        int         r;
        int         need;
        int         len;
        for (int i = 0; i < POS_SEQ_LO; i++)
        begin
            body.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = POS_SEQ_LO; i <= POS_SEQ_HI; i++)
        begin
            body.push_back(digit_byte());
        end
        for (int i = POS_SYM_LO; i <= POS_SYM_HI; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                body.push_back(ASCII_SPACE);
            end
            else if (r == 9)
            begin
                body.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                body.push_back(8'("A" + $urandom_range(0, 25)));
            end
        end
        for (int i = POS_TIME_LO; i <= POS_TIME_HI; i++)
        begin
            body.push_back(digit_byte());
        end
        flags = 8'($urandom_range(0, 255));
        flags[FLAG_NO_BOOK] = ($urandom_range(0, 3) == 0);
        body.push_back(flags);
        body.push_back(8'($urandom_range(0, 255)));
        status = 8'($urandom_range(0, 255));
        status[STATUS_SIM] = ($urandom_range(0, 5) == 0);
        body.push_back(status);
        for (int i = POS_VOL_LO; i <= POS_VOL_HI; i++)
        begin
            body.push_back(digit_byte());
        end
        need = POS_REC_START + 7 * count_records(flags, status[STATUS_SIM]);
        if (need < MIN_MSG_LEN)
        begin
            need = MIN_MSG_LEN;
        end
        while (body.size() < need)
        begin
            body.push_back(digit_byte());
        end
        case (shape)
            0:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    len = need + $urandom_range(1, 4);
                end
                else
                begin
                    len = need;
                end
            end
            1:
            begin
                len = ($urandom_range(0, 2) == 0) ? need - 1 : $urandom_range(1, need - 1);
            end
            2:
            begin
                len = $urandom_range(1, 80);
                for (int i = 0; i < body.size(); i++)
                begin
                    body[i] = 8'($urandom_range(0, 255));
                end
            end
            default:
            begin
                len = 300;
            end
        endcase
        while (body.size() < len)
        begin
            body.push_back(8'($urandom_range(0, 255)));
        end
        while (body.size() > len)
        begin
            void'(body.pop_back());
        end
        queue_message(body);
    endtask

    task automatic build_stimulus();
        logic [7:0] body[$];
        int         messages;
        int         r;
        body = '{8'h00};
        queue_message(body);
        body = '{8'hFF};
        queue_message(body);
        body = {};
        for (int i = 0; i < 20; i++)
        begin
            body.push_back((i == POS_SYM_LO + 2) ? ASCII_SPACE : ((i % 2) ? 8'hFF : 8'h00));
        end
        queue_message(body);
        messages = 0;
        while (pending_bytes.size() < 1850)
        begin
            r = $urandom_range(0, 99);
            if (messages == 12)
            begin
                queue_quote(3);
            end
            else if (r < 72)
            begin
                queue_quote(0);
            end
            else if (r < 88)
            begin
                queue_quote(1);
            end
            else
            begin
                queue_quote(2);
            end
            messages++;
        end
    endtask

    task automatic note_field(input string name, input logic [63:0] want,
                              input logic [63:0] seen, inout logic differs);
        if (want != seen)
        begin
            if (mismatch_count < 10)
            begin
                $display("mismatch in %s: expected 0x%0h, actual 0x%0h", name, want, seen);
            end
            differs = 1'b1;
        end
    endtask

    task automatic check_record();
        rec_t want;
        logic differs;
        differs = 1'b0;
        got_record.record_kind     = kind_t'(records.record_kind);
        got_record.sequence_number = records.sequence_number;
        got_record.symbol_code     = records.symbol_code;
        got_record.match_time      = records.match_time;
        got_record.total_volume    = records.total_volume;
        got_record.price_cents     = records.price_cents;
        got_record.quantity        = records.quantity;
        got_record.level_index     = records.level_index;
        got_record.content_mask    = records.content_mask;
        got_record.digit_error     = records.digit_error;
        got_record.truncated       = records.truncated;
        got_record.last_of_run     = records.last_of_run;
        if (expected_records.size() == 0)
        begin
            if (mismatch_count < 10)
            begin
                $display("unexpected record of kind %0d", got_record.record_kind);
            end
            mismatch_count++;
        end
        else
        begin
            want = expected_records.pop_front();
            note_field("record_kind", want.record_kind, got_record.record_kind, differs);
            note_field("sequence_number", want.sequence_number,
                       got_record.sequence_number, differs);
            note_field("symbol_code", want.symbol_code, got_record.symbol_code, differs);
            note_field("match_time", want.match_time, got_record.match_time, differs);
            note_field("total_volume", want.total_volume, got_record.total_volume, differs);
            note_field("price_cents", want.price_cents, got_record.price_cents, differs);
            note_field("quantity", want.quantity, got_record.quantity, differs);
            note_field("level_index", want.level_index, got_record.level_index, differs);
            note_field("content_mask", want.content_mask, got_record.content_mask, differs);
            note_field("digit_error", want.digit_error, got_record.digit_error, differs);
            note_field("truncated", want.truncated, got_record.truncated, differs);
            note_field("last_of_run", want.last_of_run, got_record.last_of_run, differs);
            if (differs)
            begin
                mismatch_count++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed.valid <= 1'b0;
            feed.data_byte <= '0;
            feed.end_of_message <= 1'b0;
            send_gap <= 0;
            clear_parser();
        end
        else
        begin
            if (feed.valid && feed.ready)
            begin
                predict_byte(feed.data_byte, feed.end_of_message);
                bytes_taken++;
            end
            if (!(feed.valid && !feed.ready))
            begin
                if (send_gap > 0)
                begin
                    feed.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_byte = pending_bytes.pop_front();
                    feed.valid <= 1'b1;
                    feed.data_byte <= next_byte.data;
                    feed.end_of_message <= next_byte.eom;
                    if ($urandom_range(0, 149) == 0)
                    begin
                        send_quiet = !send_quiet;
                    end
                    send_gap <= pick_gap(send_quiet);
                end
                else
                begin
                    feed.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            records.ready <= 1'b0;
            take_stall <= 0;
        end
        else
        begin
            if (records.valid && records.ready)
            begin
                check_record();
            end
            if (hold_off)
            begin
                records.ready <= 1'b0;
            end
            else if (take_stall > 0)
            begin
                records.ready <= 1'b0;
                take_stall <= take_stall - 1;
            end
            else
            begin
                records.ready <= 1'b1;
                if ($urandom_range(0, 149) == 0)
                begin
                    take_quiet = !take_quiet;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    take_stall <= pick_gap(take_quiet);
                end
            end
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (bytes_taken >= 700);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        build_stimulus();
        wait (rst_n === 1'b1);
        while (pending_bytes.size() > 0 || feed.valid)
        begin
            @(posedge clk);
        end
        while (expected_records.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
        if (mismatch_count == 0 && expected_records.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #8000000;
        $display("simulation failed");
        $finish;
    end

endmodule
